// ===== rtl/uqkb_pkg.sv =====
// Shared types and constants for the URL query key blocklist matcher.
// Holds the table geometry, the item codes, the special URL characters and the beat structs.
// Depends on nothing; every other file imports it.
package uqkb_pkg;

    // Key table geometry.
    localparam int NUM_KEYS = 16;
    localparam int KEY_LEN  = 16;

    // Derived widths: one memory row per key position, one byte lane per slot.
    localparam int ROW_AW = $clog2(KEY_LEN);
    localparam int POS_W  = $clog2(KEY_LEN + 1);
    localparam int ROW_W  = NUM_KEYS * 8;

    // Item codes carried in the mode field.
    typedef enum logic [1:0] {
        MODE_URL      = 2'd0,
        MODE_KEY_CHAR = 2'd1,
        MODE_KEY_LEN  = 2'd2,
        MODE_CLEAR    = 2'd3
    } t_mode;

    // URL characters that steer the parser.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_HASH    = 8'h23;

    // Input beat.
    typedef struct packed {
        t_mode       mode;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [3:0]  slot_index;
        logic [3:0]  char_position;
        logic [4:0]  key_length;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic has_tracking_param;
        logic table_ready;
    } t_out_beat;

endpackage

// ===== rtl/url_query_key_blocklist_match.sv =====
// Top level of the URL query key blocklist matcher.
// Holds the input register, the parser, the key table and the result register.
// Depends on uqkb_pkg.

// The block takes one beat per clock cycle while no result beat is held back. An accepted
// beat sits in the input register and goes through the parser into the result register.
// Beats in mode 0 carry URL bytes; a result beat appears only for the beat with
// last_byte set, and its verdict is forced low until a clear beat (mode 3) has initialized
// the table. Key table writes (modes 1 to 3) take effect for the very next beat, even in the
// middle of a URL. The key characters live in a memory with one row per key position and one
// byte lane per slot; the row for the next key position is read ahead each cycle, so all
// slots are compared in parallel at one byte per cycle unless stalled. The only stall comes from the output
// side: a result beat waits while the result register is full and not taken, while beats
// that give no result keep flowing.
module url_query_key_blocklist_match (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  uqkb_pkg::t_in_beat i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output uqkb_pkg::t_out_beat o_out_data
);
    import uqkb_pkg::*;

    typedef enum logic [1:0] {
        PH_PRE   = 2'd0,
        PH_QUERY = 2'd1,
        PH_FRAG  = 2'd2
    } t_phase;

    // Handshake and payload registers.
    logic      r_in_valid, n_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out, n_out;

    // Parser and table state.
    t_phase              r_phase, n_phase;
    logic                r_in_key, n_in_key;
    logic [POS_W-1:0]    r_key_pos, n_key_pos;
    logic                r_found, n_found;
    logic                r_init, n_init;
    logic [NUM_KEYS-1:0] r_match, n_match;
    logic [4:0]          r_len [NUM_KEYS];
    logic [4:0]          n_len [NUM_KEYS];

    // Key character memory and the prefetched row.
    logic [ROW_W-1:0]  mem [KEY_LEN];
    logic [ROW_W-1:0]  r_row;
    logic [ROW_AW-1:0] rd_addr, wr_addr;
    logic              wr_en;

    // Per-slot compare results.
    logic                is_result, fire, accept;
    logic [NUM_KEYS-1:0] len_eq_now, len_eq_inc, char_eq, sel_eq;
    logic                hit_now, final_hit;
    logic [7:0]          c;

    assign c         = r_in.data_byte;
    assign is_result = (r_in.mode == MODE_URL) && r_in.last_byte;
    assign fire      = r_in_valid && (!is_result || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign accept    = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Slot length checks against the current key position and the one after it.
    always_comb begin
        for (int s = 0; s < NUM_KEYS; s++) begin
            len_eq_now[s] = (r_len[s] != 5'd0) && (32'(r_len[s]) <= KEY_LEN)
                            && (32'(r_len[s]) == 32'(r_key_pos));
            len_eq_inc[s] = (r_len[s] != 5'd0) && (32'(r_len[s]) <= KEY_LEN)
                            && (32'(r_len[s]) == 32'(r_key_pos) + 1);
            char_eq[s]    = (r_row[s*8 +: 8] == c);
        end
        hit_now = (r_key_pos != '0) && (|(r_match & len_eq_now));
    end

    // Next state of the parser, the table and the handshake registers.
    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_phase     = r_phase;
        n_in_key    = r_in_key;
        n_key_pos   = r_key_pos;
        n_found     = r_found;
        n_init      = r_init;
        n_match     = r_match;
        n_len       = r_len;
        wr_en       = 1'b0;
        sel_eq      = len_eq_now;
        final_hit   = 1'b0;

        if (accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (fire) begin
            case (r_in.mode)
                MODE_KEY_CHAR: begin
                    wr_en = (32'(r_in.slot_index) < NUM_KEYS)
                            && (32'(r_in.char_position) < KEY_LEN);
                end
                MODE_KEY_LEN: begin
                    for (int s = 0; s < NUM_KEYS; s++) begin
                        if (32'(r_in.slot_index) == s) begin
                            n_len[s] = r_in.key_length;
                        end
                    end
                end
                MODE_CLEAR: begin
                    for (int s = 0; s < NUM_KEYS; s++) begin
                        n_len[s] = 5'd0;
                    end
                    n_init = 1'b1;
                end
                MODE_URL: begin
                    case (r_phase)
                        PH_PRE: begin
                            if (c == CH_QMARK) begin
                                n_phase   = PH_QUERY;
                                n_match   = '1;
                                n_in_key  = 1'b1;
                                n_key_pos = '0;
                            end
                        end
                        PH_QUERY: begin
                            if (c == CH_HASH) begin
                                if (r_in_key && hit_now) begin
                                    n_found = 1'b1;
                                end
                                n_phase = PH_FRAG;
                            end else if (c == CH_PERCENT) begin
                                n_found = 1'b1;
                            end else if (c == CH_AMP) begin
                                if (r_in_key && hit_now) begin
                                    n_found = 1'b1;
                                end
                                n_match   = '1;
                                n_in_key  = 1'b1;
                                n_key_pos = '0;
                            end else if (r_in_key) begin
                                if (c == CH_EQ) begin
                                    if (hit_now) begin
                                        n_found = 1'b1;
                                    end
                                    n_in_key = 1'b0;
                                end else if (32'(r_key_pos) >= KEY_LEN) begin
                                    // An overlong key can match no slot.
                                    n_match = '0;
                                end else begin
                                    n_match   = r_match & char_eq;
                                    n_key_pos = r_key_pos + POS_W'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase

                    // The last byte closes any key still open and issues the verdict.
                    if (r_in.last_byte) begin
                        sel_eq    = (n_key_pos == r_key_pos) ? len_eq_now : len_eq_inc;
                        final_hit = (n_phase == PH_QUERY) && n_in_key && (n_key_pos != '0)
                                    && (|(n_match & sel_eq));
                        n_out.has_tracking_param = n_init && (n_found || final_hit);
                        n_out.table_ready        = n_init;
                        n_out_valid = 1'b1;
                        n_phase     = PH_PRE;
                        n_found     = 1'b0;
                        n_match     = '1;
                        n_in_key    = 1'b1;
                        n_key_pos   = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Memory addresses: write at the beat's position, read ahead at the next key position.
    assign wr_addr = ROW_AW'(r_in.char_position);
    assign rd_addr = (!i_rst_n || (32'(n_key_pos) >= KEY_LEN)) ? '0 : ROW_AW'(n_key_pos);

    // Key character memory with a bypass so that a write shows in the row read at once.
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NUM_KEYS; s++) begin
            if (wr_en && (32'(r_in.slot_index) == s)) begin
                mem[wr_addr][s*8 +: 8] <= r_in.data_byte;
            end
            if (wr_en && (wr_addr == rd_addr) && (32'(r_in.slot_index) == s)) begin
                r_row[s*8 +: 8] <= r_in.data_byte;
            end else begin
                r_row[s*8 +: 8] <= mem[rd_addr][s*8 +: 8];
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_PRE;
            r_in_key    <= 1'b1;
            r_key_pos   <= '0;
            r_found     <= 1'b0;
            r_init      <= 1'b0;
            r_match     <= '1;
            for (int s = 0; s < NUM_KEYS; s++) begin
                r_len[s] <= 5'd0;
            end
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
            r_phase     <= n_phase;
            r_in_key    <= n_in_key;
            r_key_pos   <= n_key_pos;
            r_found     <= n_found;
            r_init      <= n_init;
            r_match     <= n_match;
            r_len       <= n_len;
            if (accept) begin
                r_in <= i_in_data;
            end
        end
    end

endmodule

// ===== rtl/uqkb_checker.sv =====
// Port-level checks for the URL query key blocklist matcher.
// Holds the checker module and the bind that attaches it to the top level.
// Depends on uqkb_pkg and url_query_key_blocklist_match.
module uqkb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input uqkb_pkg::t_in_beat  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input uqkb_pkg::t_out_beat o_out_data
);
    import uqkb_pkg::*;

    // Remembers that a result beat has already shown an initialized table.
    logic r_seen_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_out_data.table_ready) begin
            r_seen_ready <= 1'b1;
        end
    end

    // An input beat that waits for the block stays put.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_in_data)))
        else $error("input beat changed while stalled");

    // A result beat held back by the receiver stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result beat changed while stalled");

    // A positive verdict is only given for an initialized table.
    a_verdict_needs_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.has_tracking_param || o_out_data.table_ready))
        else $error("verdict raised before table initialization");

    // Once initialized, the table stays initialized for every later result.
    a_ready_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_seen_ready) |-> o_out_data.table_ready)
        else $error("table_ready dropped after initialization");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result beat valid right after reset");

endmodule

bind url_query_key_blocklist_match uqkb_checker u_uqkb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== sim/tb_url_query_key_blocklist_match.sv =====
// Self-checking testbench for the URL query key blocklist matcher.
// Streams key table loads and URLs under random handshake gaps and checks every verdict.
// Depends on uqkb_pkg and url_query_key_blocklist_match.
`timescale 1ns / 1ps

module tb_url_query_key_blocklist_match;
    import uqkb_pkg::*;

    localparam int IN_W          = $bits(t_in_beat);
    localparam int RANDOM_BEATS  = 1530;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    // Where the parser stands within the current URL.
    typedef enum logic [1:0] {
        PH_HOST,
        PH_QUERY,
        PH_FRAGMENT
    } t_parse_phase;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_data;

    int src_idle_pct;
    int sink_idle_pct;
    int beats_sent;
    int verdicts_checked;
    int verdicts_flagged;
    int mismatches;

    // Predictor state: key table, per-slot match flags and the URL parser.
    bit [7:0]     key_mem     [NUM_KEYS][KEY_LEN];
    bit [4:0]     key_len_mem [NUM_KEYS];
    bit           slot_live   [NUM_KEYS];
    t_parse_phase parse_st;
    bit           scanning_key;
    int           key_depth;
    bit           hit;
    bit           table_init;

    // Verdicts predicted for accepted URL ends, oldest first.
    t_out_beat pending_verdicts[$];

    // Scratch buffer for the URL under construction.
    logic [7:0] url_bytes[$];

    url_query_key_blocklist_match dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    // The result side stalls at random.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // ---------------------------------------------------------------- prediction

    function automatic void restart_part();
        foreach (slot_live[s]) slot_live[s] = 1'b1;
        scanning_key = 1'b1;
        key_depth    = 0;
    endfunction

    function automatic void reset_prediction();
        parse_st   = PH_HOST;
        hit        = 1'b0;
        table_init = 1'b0;
        restart_part();
    endfunction

    // A finished, non-empty key hits every slot that still matches and has its length.
    function automatic void close_key();
        if (key_depth == 0) return;
        foreach (key_len_mem[s]) begin
            if (slot_live[s] && key_len_mem[s] != 0 && key_len_mem[s] <= KEY_LEN &&
                key_len_mem[s] == key_depth) begin
                hit = 1'b1;
            end
        end
    endfunction

    // One key character against all slots; past KEY_LEN nothing can match.
    function automatic void take_key_char(logic [7:0] c);
        if (key_depth >= KEY_LEN) begin
            foreach (slot_live[s]) slot_live[s] = 1'b0;
            return;
        end
        foreach (slot_live[s]) begin
            if (key_mem[s][key_depth] != c) slot_live[s] = 1'b0;
        end
        key_depth++;
    endfunction

    function automatic void take_url_char(logic [7:0] c);
        case (parse_st)
            PH_HOST: begin
                if (c == CH_QMARK) begin
                    parse_st = PH_QUERY;
                    restart_part();
                end
            end
            PH_QUERY: begin
                if (c == CH_HASH) begin
                    if (scanning_key) close_key();
                    parse_st = PH_FRAGMENT;
                end else if (c == CH_PERCENT) begin
                    hit = 1'b1;
                end else if (c == CH_AMP) begin
                    if (scanning_key) close_key();
                    restart_part();
                end else if (scanning_key) begin
                    if (c == CH_EQ) begin
                        close_key();
                        scanning_key = 1'b0;
                    end else begin
                        take_key_char(c);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Applies one accepted beat and queues a verdict when it ends a URL.
    function automatic void predict_verdict(t_in_beat b);
        t_out_beat v;
        case (b.mode)
            MODE_KEY_CHAR: begin
                if (b.slot_index < NUM_KEYS && b.char_position < KEY_LEN)
                    key_mem[b.slot_index][b.char_position] = b.data_byte;
            end
            MODE_KEY_LEN: begin
                if (b.slot_index < NUM_KEYS) key_len_mem[b.slot_index] = b.key_length;
            end
            MODE_CLEAR: begin
                foreach (key_len_mem[s]) key_len_mem[s] = '0;
                table_init = 1'b1;
            end
            MODE_URL: begin
                take_url_char(b.data_byte);
                if (b.last_byte) begin
                    if (parse_st == PH_QUERY && scanning_key) close_key();
                    v.has_tracking_param = table_init && hit;
                    v.table_ready        = table_init;
                    pending_verdicts = {pending_verdicts, v};
                    parse_st = PH_HOST;
                    hit      = 1'b0;
                    restart_part();
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, what);
    endfunction

    // Result beats are checked before the same edge's input beat is predicted.
    always @(posedge i_clk) begin : check_verdicts
        t_out_beat want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_verdicts.size() == 0) begin
                    note_mismatch($sformatf("result %b arrived with no URL end pending",
                                            o_out_data));
                end else begin
                    want = pending_verdicts.pop_front();
                    verdicts_checked++;
                    if (want.has_tracking_param) verdicts_flagged++;
                    if (o_out_data.has_tracking_param !== want.has_tracking_param)
                        note_mismatch($sformatf("verdict %0d has_tracking_param exp %b got %b",
                            verdicts_checked, want.has_tracking_param,
                            o_out_data.has_tracking_param));
                    if (o_out_data.table_ready !== want.table_ready)
                        note_mismatch($sformatf("verdict %0d table_ready exp %b got %b",
                            verdicts_checked, want.table_ready, o_out_data.table_ready));
                end
            end
            if (i_in_valid && o_in_ready) predict_verdict(i_in_data);
        end
    end

    // ---------------------------------------------------------------- beat builders

    // Unused fields of every beat carry random bits.
    function automatic t_in_beat raw_beat();
        return t_in_beat'(IN_W'($urandom));
    endfunction

    function automatic t_in_beat url_beat(logic [7:0] c, logic is_end);
        t_in_beat b;
        b           = raw_beat();
        b.mode      = MODE_URL;
        b.data_byte = c;
        b.last_byte = is_end;
        return b;
    endfunction

    function automatic t_in_beat key_char_beat(int slot, int pos, logic [7:0] c);
        t_in_beat b;
        b               = raw_beat();
        b.mode          = MODE_KEY_CHAR;
        b.slot_index    = 4'(slot);
        b.char_position = 4'(pos);
        b.data_byte     = c;
        return b;
    endfunction

    function automatic t_in_beat key_len_beat(int slot, int len);
        t_in_beat b;
        b            = raw_beat();
        b.mode       = MODE_KEY_LEN;
        b.slot_index = 4'(slot);
        b.key_length = 5'(len);
        return b;
    endfunction

    function automatic t_in_beat clear_beat();
        t_in_beat b;
        b      = raw_beat();
        b.mode = MODE_CLEAR;
        return b;
    endfunction

    // Mostly a small alphabet so that keys collide often, sometimes any byte.
    function automatic logic [7:0] pick_key_char();
        if ($urandom_range(0, 99) < 80) return 8'("a" + $urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_host_char();
        if ($urandom_range(0, 99) < 85) return 8'("a" + $urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    // Short keys dominate; full-length, empty and overlong slots show up too.
    function automatic int pick_key_len();
        int r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(1, 4);
        if (r < 65) return KEY_LEN;
        if (r < 80) return $urandom_range(5, KEY_LEN - 1);
        if (r < 88) return 0;
        return $urandom_range(KEY_LEN + 1, 31);
    endfunction

    // ---------------------------------------------------------------- sending

    // Drives one beat and returns at the edge that accepts it.
    task automatic send_beat(t_in_beat b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // Stops sending until every predicted verdict has come back.
    task automatic wait_for_verdicts();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_key(int slot, string key_text);
        for (int p = 0; p < key_text.len(); p++)
            send_beat(key_char_beat(slot, p, key_text[p]));
        send_beat(key_len_beat(slot, key_text.len()));
    endtask

    task automatic send_url(string url_text);
        for (int i = 0; i < url_text.len(); i++)
            send_beat(url_beat(url_text[i], i == url_text.len() - 1));
    endtask

    task automatic load_random_key(int slot);
        int len;
        len = pick_key_len();
        for (int p = 0; p < len && p < KEY_LEN; p++)
            send_beat(key_char_beat(slot, p, pick_key_char()));
        send_beat(key_len_beat(slot, len));
    endtask

    task automatic random_table_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            send_beat(key_char_beat($urandom_range(0, NUM_KEYS - 1),
                                    $urandom_range(0, KEY_LEN - 1), pick_key_char()));
        else if (r < 90)
            send_beat(key_len_beat($urandom_range(0, NUM_KEYS - 1), pick_key_len()));
        else
            send_beat(clear_beat());
    endtask

    // Adds one byte at the end of the URL under construction.
    function automatic void add_url_byte(logic [7:0] c);
        url_bytes = {url_bytes, c};
    endfunction

    // Appends a query key: often a replay of a loaded key, sometimes cut short
    // or one character too long, otherwise random text up to past KEY_LEN.
    function automatic void append_query_key();
        int s;
        int n;
        s = $urandom_range(0, NUM_KEYS - 1);
        if ($urandom_range(0, 99) < 45) begin
            repeat (4) begin
                if (key_len_mem[s] == 0 || key_len_mem[s] > KEY_LEN)
                    s = $urandom_range(0, NUM_KEYS - 1);
            end
            n = (key_len_mem[s] > KEY_LEN) ? KEY_LEN : key_len_mem[s];
            for (int p = 0; p < n; p++) add_url_byte(key_mem[s][p]);
            case ($urandom_range(0, 9))
                0: if (n > 0) void'(url_bytes.pop_back());
                1: add_url_byte(pick_key_char());
                default: ;
            endcase
        end else begin
            repeat ($urandom_range(0, KEY_LEN + 2)) add_url_byte(pick_key_char());
        end
    endfunction

    // Builds one mostly well-formed URL and sends it, with occasional table
    // changes slipped in between its bytes.
    task automatic send_random_url();
        int parts;
        url_bytes.delete();
        repeat ($urandom_range(0, 5)) add_url_byte(pick_host_char());
        if ($urandom_range(0, 9) == 0) add_url_byte(CH_HASH);
        if ($urandom_range(0, 9) != 0) begin
            add_url_byte(CH_QMARK);
            parts = $urandom_range(1, 4);
            for (int i = 0; i < parts; i++) begin
                if (i != 0) add_url_byte(CH_AMP);
                append_query_key();
                if ($urandom_range(0, 1) == 1) begin
                    add_url_byte(CH_EQ);
                    repeat ($urandom_range(0, 4)) add_url_byte(pick_key_char());
                end
                if ($urandom_range(0, 99) < 5) add_url_byte(CH_PERCENT);
            end
            if ($urandom_range(0, 99) < 15) begin
                add_url_byte(CH_HASH);
                repeat ($urandom_range(0, 4)) add_url_byte(pick_key_char());
            end
        end
        if (url_bytes.size() == 0) add_url_byte(pick_host_char());
        foreach (url_bytes[i]) begin
            if ($urandom_range(0, 99) < 3) random_table_op();
            send_beat(url_beat(url_bytes[i], i == url_bytes.size() - 1));
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Writes every key character once so that no comparison ever reads an unwritten entry.
    task automatic test_key_table_preload();
        foreach (key_mem[s, p]) send_beat(key_char_beat(s, p, pick_key_char()));
    endtask

    // Before the first clear the verdict and the ready flag stay low.
    task automatic test_before_init();
        load_key(3, "id");
        send_url("?id%");
    endtask

    // Exact match, hash before the query, split on ampersand, key used as a
    // value, percent after the fragment, and a bare percent.
    task automatic test_directed_queries();
        send_beat(clear_beat());
        load_key(3, "id");
        send_url("?id");
        send_url("#?i&id");
        send_url("?i=id#%");
        send_url("?%");
    endtask

    task automatic test_random_traffic(int src_pct, int sink_pct, int count);
        int goal;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        goal          = beats_sent + count;
        while (beats_sent < goal) begin
            if ($urandom_range(0, 99) < 35) load_random_key($urandom_range(0, NUM_KEYS - 1));
            if ($urandom_range(0, 99) < 3) send_beat(raw_beat());
            send_random_url();
        end
        wait_for_verdicts();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_data     <= '0;
        i_out_ready   <= 1'b0;
        src_idle_pct  = 7;
        sink_idle_pct = 82;
        reset_prediction();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_key_table_preload();
        test_before_init();
        test_directed_queries();
        wait_for_verdicts();
        test_random_traffic(7, 82, RANDOM_BEATS / 3);
        test_random_traffic(82, 7, RANDOM_BEATS / 3);
        test_random_traffic(0, 0, RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));

        if (pending_verdicts.size() != 0)
            note_mismatch($sformatf("%0d URL verdicts never arrived",
                                    pending_verdicts.size()));

        $display("Sent %0d beats and checked %0d URL verdicts, %0d of them flagged.",
                 beats_sent, verdicts_checked, verdicts_flagged);
        $display("Traffic mixed table loads, clears and mid-URL changes under three stall mixes.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/uqkb_pkg.sv
rtl/url_query_key_blocklist_match.sv
rtl/uqkb_checker.sv
sim/tb_url_query_key_blocklist_match.sv
